FILE: rtl/onnh_pkg.sv
// ----------------------------------------------------------------------------
// Ordered neighbour next-hop package
// Shared widths, table depth, operation codes, register indexes and route
// case codes for the next-hop block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package onnh_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int CASE_BITS   = 4;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_BITS  = IDX_BITS + 3 * ID_BITS;
    localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ID_BITS + CASE_BITS;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SELF_ID     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_BASE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRY_COUNT = 2'd2;

    // Request kinds.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    // Route decision codes.
    localparam logic [CASE_BITS-1:0] RC_SELF        = 4'd0;
    localparam logic [CASE_BITS-1:0] RC_NEIGHBOUR   = 4'd1;
    localparam logic [CASE_BITS-1:0] RC_OUT_LEFT0   = 4'd2;
    localparam logic [CASE_BITS-1:0] RC_OUT_RBASE   = 4'd3;
    localparam logic [CASE_BITS-1:0] RC_OUT_LTAG    = 4'd4;
    localparam logic [CASE_BITS-1:0] RC_OUT_RIGHT   = 4'd5;
    localparam logic [CASE_BITS-1:0] RC_NEAR_ABOVE  = 4'd6;
    localparam logic [CASE_BITS-1:0] RC_FAR_BELOW   = 4'd7;
    localparam logic [CASE_BITS-1:0] RC_NEAR_BELOW  = 4'd8;
    localparam logic [CASE_BITS-1:0] RC_FAR_ABOVE   = 4'd9;

    typedef logic [ID_BITS-1:0]  id_t;
    typedef logic [IDX_BITS-1:0] idx_t;

endpackage : onnh_pkg

`default_nettype wire

FILE: rtl/ordered_neighbour_next_hop.sv
// ----------------------------------------------------------------------------
// Ordered neighbour next-hop table
// Stores neighbour entries and picks the next hop for route requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ stream. A write request (tuser = 0) stores one
// id/tag pair at entry_index; a route request (tuser = 1) looks up target.
// Every request yields exactly one result on the m_ stream: the next hop and
// a case code for routes, zeros for writes, and an error flag in tuser for a
// write whose index lies beyond the last entry, the count clamped to 1..16.
// Timing: a request waits in the input register, where all in-use
// entries are compared against the target in parallel; the decision is
// registered into the output register as soon as the output is free, and
// one request is taken every cycle while m_tready stays high. The
// single-pass parallel comparison of the 16 entries sets that rate.
// A write updates the table as it leaves the input register, so the very
// next route request already sees it.
// When m_tready is low the output holds, the input register fills, and then
// s_tready drops until the result is taken. Synchronous reset empties both
// registers and loads self id = 0, right base id = 0 and entry_count = 1;
// table contents are not cleared and must be written before being used.
// Configuration writes are applied at any edge with cfg_wr_en high and reset released.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_neighbour_next_hop
    import onnh_pkg::*;
(
    input  wire                      aclk,
    input  wire                      aresetn,
    // Configuration write port.
    input  wire                      cfg_wr_en,
    input  wire [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire [ID_BITS-1:0]        cfg_wdata,
    // Request stream.
    input  wire                      s_tvalid,
    output logic                     s_tready,
    // s_tdata, low bit up: entry_index, neighbour id, neighbour tag, target,
    // zero pad.
    input  wire [IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: operation.
    input  wire [0:0]                s_tuser,
    // Result stream.
    output logic                     m_tvalid,
    input  wire                      m_tready,
    // m_tdata, low bit up: next_hop, route_case, zero pad.
    output logic [OUT_TDATA_W-1:0]   m_tdata,
    // m_tuser: error.
    output logic [0:0]               m_tuser
);

    // Configuration registers.
    id_t                 self_id_reg;
    id_t                 right_base_reg;
    logic [CNT_BITS-1:0] entry_count_reg;

    // Neighbour table.
    id_t ids_reg  [TABLE_DEPTH];
    id_t tags_reg [TABLE_DEPTH];

    // Input register.
    logic item_vld_reg;
    logic op_reg;
    idx_t idx_reg;
    id_t  eid_reg;
    id_t  etag_reg;
    id_t  tgt_reg;

    // Output register.
    logic                 out_vld_reg;
    id_t                  hop_reg;
    logic [CASE_BITS-1:0] case_reg;
    logic                 err_reg;

    id_t                  hop_next;
    logic [CASE_BITS-1:0] case_next;
    logic                 err_next;

    logic advance;
    logic table_wr;
    idx_t last_idx;

    // The item in the input register moves on whenever the output is free.
    assign advance  = item_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !item_vld_reg || advance;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_DATA_BITS){1'b0}}, case_reg, hop_reg};
    assign m_tuser  = err_reg;

    // Clamp the configured count into 1..TABLE_DEPTH and keep its last position.
    always_comb begin
        if (entry_count_reg == '0) begin
            last_idx = '0;
        end else if (entry_count_reg > CNT_BITS'(TABLE_DEPTH)) begin
            last_idx = IDX_BITS'(TABLE_DEPTH - 1);
        end else begin
            last_idx = IDX_BITS'(entry_count_reg - CNT_BITS'(1));
        end
    end

    assign table_wr = advance && (op_reg == OP_WRITE) && (idx_reg <= last_idx);

    // Route decision. Entry selection is one-hot so every entry is read at a
    // fixed place; the pairwise compares decide which entry wins each search.
    logic [TABLE_DEPTH-1:0] in_use;
    logic [TABLE_DEPTH-1:0] lt_t;
    logic [TABLE_DEPTH-1:0] gt_t;
    logic [TABLE_DEPTH-1:0] below_oh;
    logic [TABLE_DEPTH-1:0] above_oh;
    logic [TABLE_DEPTH-1:0] last_oh;
    logic                   hit;
    id_t                    left_id;
    id_t                    right_id;
    id_t                    right_tag;
    id_t                    below_id;
    id_t                    below_tag;
    id_t                    above_id;
    id_t                    above_tag;

    always_comb begin
        in_use    = '0;
        lt_t      = '0;
        gt_t      = '0;
        last_oh   = '0;
        hit       = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            in_use[i]  = (IDX_BITS'(i) <= last_idx);
            last_oh[i] = (IDX_BITS'(i) == last_idx);
            lt_t[i]    = in_use[i] && (ids_reg[i] < tgt_reg);
            gt_t[i]    = in_use[i] && (ids_reg[i] > tgt_reg);
            hit        = hit || (in_use[i] && (ids_reg[i] == tgt_reg));
        end

        // An entry wins "below" when it beats every other candidate: larger
        // id, or equal id at a lower position. "Above" mirrors this.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            below_oh[i] = lt_t[i];
            above_oh[i] = gt_t[i];
            for (int j = 0; j < TABLE_DEPTH; j++) begin
                if (j != i) begin
                    if (lt_t[j] && !((ids_reg[i] > ids_reg[j]) ||
                                     ((ids_reg[i] == ids_reg[j]) && (i < j)))) begin
                        below_oh[i] = 1'b0;
                    end
                    if (gt_t[j] && !((ids_reg[i] < ids_reg[j]) ||
                                     ((ids_reg[i] == ids_reg[j]) && (i < j)))) begin
                        above_oh[i] = 1'b0;
                    end
                end
            end
        end

        // With no qualifying entry, fall back to the first or last position.
        if (below_oh == '0) begin
            below_oh    = '0;
            below_oh[0] = 1'b1;
        end
        if (above_oh == '0) begin
            above_oh = last_oh;
        end

        left_id   = ids_reg[0];
        right_id  = '0;
        right_tag = '0;
        below_id  = '0;
        below_tag = '0;
        above_id  = '0;
        above_tag = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            right_id  = right_id  | (ids_reg[i]  & {ID_BITS{last_oh[i]}});
            right_tag = right_tag | (tags_reg[i] & {ID_BITS{last_oh[i]}});
            below_id  = below_id  | (ids_reg[i]  & {ID_BITS{below_oh[i]}});
            below_tag = below_tag | (tags_reg[i] & {ID_BITS{below_oh[i]}});
            above_id  = above_id  | (ids_reg[i]  & {ID_BITS{above_oh[i]}});
            above_tag = above_tag | (tags_reg[i] & {ID_BITS{above_oh[i]}});
        end
    end

    always_comb begin
        hop_next  = '0;
        case_next = RC_SELF;
        err_next  = 1'b0;
        if (op_reg == OP_WRITE) begin
            err_next = (idx_reg > last_idx);
        end else if (tgt_reg == self_id_reg) begin
            hop_next  = tgt_reg;
            case_next = RC_SELF;
        end else if (hit) begin
            hop_next  = tgt_reg;
            case_next = RC_NEIGHBOUR;
        end else if ((tgt_reg < left_id) || (right_id < tgt_reg)) begin
            // Target lies outside the span of the table.
            if (left_id == '0) begin
                hop_next  = left_id;
                case_next = RC_OUT_LEFT0;
            end else if (right_id == right_base_reg) begin
                hop_next  = right_id;
                case_next = RC_OUT_RBASE;
            end else if (left_id < right_tag) begin
                hop_next  = left_id;
                case_next = RC_OUT_LTAG;
            end else begin
                hop_next  = right_id;
                case_next = RC_OUT_RIGHT;
            end
        end else if (tgt_reg < self_id_reg) begin
            // Target left of this node: the entry just above may cover it.
            if ((above_tag <= tgt_reg) && (tgt_reg <= above_id)) begin
                hop_next  = above_id;
                case_next = RC_NEAR_ABOVE;
            end else begin
                hop_next  = below_id;
                case_next = RC_FAR_BELOW;
            end
        end else begin
            // Target right of this node: the entry just below may cover it.
            if ((below_id <= tgt_reg) && (tgt_reg <= below_tag)) begin
                hop_next  = below_id;
                case_next = RC_NEAR_BELOW;
            end else begin
                hop_next  = above_id;
                case_next = RC_FAR_ABOVE;
            end
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg    <= 1'b0;
            out_vld_reg     <= 1'b0;
            self_id_reg     <= '0;
            right_base_reg  <= '0;
            entry_count_reg <= CNT_BITS'(1);
        end else begin
            if (s_tready) begin
                item_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SELF_ID:     self_id_reg     <= cfg_wdata;
                    CFG_RIGHT_BASE:  right_base_reg  <= cfg_wdata;
                    CFG_ENTRY_COUNT: entry_count_reg <= cfg_wdata[CNT_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers and the table need no reset.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg   <= s_tuser[0];
            idx_reg  <= s_tdata[IDX_BITS-1:0];
            eid_reg  <= s_tdata[IDX_BITS +: ID_BITS];
            etag_reg <= s_tdata[IDX_BITS + ID_BITS +: ID_BITS];
            tgt_reg  <= s_tdata[IDX_BITS + 2 * ID_BITS +: ID_BITS];
        end
        if (advance) begin
            hop_reg  <= hop_next;
            case_reg <= case_next;
            err_reg  <= err_next;
        end
        if (table_wr) begin
            ids_reg[idx_reg]  <= eid_reg;
            tags_reg[idx_reg] <= etag_reg;
        end
    end

endmodule : ordered_neighbour_next_hop

`default_nettype wire

FILE: rtl/onnh_checker.sv
// ----------------------------------------------------------------------------
// Ordered neighbour next-hop checker
// Port-level assertions for the next-hop block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module onnh_checker
    import onnh_pkg::*;
(
    input wire                    aclk,
    input wire                    aresetn,
    input wire                    s_tready,
    input wire                    m_tvalid,
    input wire                    m_tready,
    input wire [OUT_TDATA_W-1:0]  m_tdata,
    input wire [0:0]              m_tuser
);

    // Reset empties the output register.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Only defined route codes come out.
    a_case_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[ID_BITS +: CASE_BITS] <= RC_FAR_ABOVE)
        else $error("route case out of range");

    // A rejected write carries no hop and no case.
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("error result carries route data");

    // With the output register empty, a request can always be taken.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty output");

endmodule : onnh_checker

bind ordered_neighbour_next_hop onnh_checker u_onnh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
